// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int ResNumWidth  = 34;
  localparam int ResDenWidth  = 31;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [OperandWidth-1:0] a_num;
    logic [OperandWidth-1:0] a_den;
    logic [OperandWidth-1:0] b_num;
    logic [OperandWidth-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic [ResNumWidth-1:0] res_num;
    logic [ResDenWidth-1:0] res_den;
    logic [1:0]             status;
  } rau_out_t;

endpackage

// ===== src/rau_divider.sv =====
// ----------------------------------------------------------------------------
// rau_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W:0]    trial;

  // shift in next dividend bit and try the subtract
  assign trial = {r, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        q       <= dividend;
        r       <= '0;
        d       <= divisor;
        cnt     <= CW'(W);
      end else if (running) begin
        if (!trial[W]) begin
          r <= trial[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= {r[W-2:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply or divide two signed fractions, reduced result
// ----------------------------------------------------------------------------
// Usage: drive the operand beat on operands and pulse start while busy is
// low. The beat is taken at that edge and busy rises at once. The block
// forms the cross products and the denominator product one multiply a
// cycle, then runs the Euclid loop on a shared restoring divider (one
// quotient bit a cycle), then divides numerator and denominator by the
// gcd on the same divider. The result beat is held on result and marked
// by valid for one cycle, and busy falls in that cycle. Error cases go
// from the check straight to the output, and a zero numerator skips the
// divider. A new start is taken in the valid cycle.
// The receiver cannot stall: valid is a one-cycle strobe.
// Reset returns the sequencer to idle and drops valid and busy.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rau_pkg::rau_in_t  operands,
  output logic              busy,
  output logic              valid,
  output rau_pkg::rau_out_t result
);
  import rau_pkg::*;

  localparam int OW = OperandWidth;
  localparam int PW = 2 * OW + 1;   // product/sum magnitude width

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_MUL3, S_SUM,
    S_GCD, S_STEP, S_GCDW, S_DIVN, S_DIVNW, S_DIVD, S_DIVDW, S_OUT
  } state_t;

  state_t      state;
  logic [1:0]  func;
  logic [OW-1:0] an, ad, bn, bd;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [PW-1:0] p1, p2;
  logic        p1_s, p2_s;
  logic [PW-1:0] num, den, gx, gy;
  logic        num_s, den_s;

  logic [OW-1:0] op_a, op_b;
  logic [PW-1:0] prod;
  logic          div_go, div_done;
  logic [PW-1:0] div_a, div_b, div_q, div_r;

  function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
    return v[OW-1] ? (~v + 1'b1) : v;
  endfunction

  // single shared multiplier, operands chosen by the sequencer
  assign prod = PW'(op_a) * PW'(op_b);

  always_comb begin
    op_a = an;
    op_b = bd;
    case (state)
      S_MUL1: begin
        op_a = an;
        op_b = (func == FUNC_MUL) ? bn : bd;
      end
      S_MUL2: begin
        op_a = (func == FUNC_DIV) ? bd : bn;
        op_b = (func == FUNC_DIV) ? an : ad;
      end
      S_MUL3: begin
        op_a = ad;
        op_b = (func == FUNC_DIV) ? bn : bd;
      end
      default: begin
        op_a = an;
        op_b = bd;
      end
    endcase
  end

  assign div_go = (state == S_STEP) || (state == S_DIVN) || (state == S_DIVD);
  always_comb begin
    case (state)
      S_DIVN:  begin div_a = num; div_b = gx; end
      S_DIVD:  begin div_a = den; div_b = gx; end
      default: begin div_a = gx;  div_b = gy; end
    endcase
  end

  rau_divider #(.W(PW)) u_div (
    .clk, .rst,
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            func  <= operands.func;
            an    <= mag(operands.a_num);
            ad    <= mag(operands.a_den);
            bn    <= mag(operands.b_num);
            bd    <= mag(operands.b_den);
            an_s  <= operands.a_num[OW-1];
            ad_s  <= operands.a_den[OW-1];
            bn_s  <= operands.b_num[OW-1];
            bd_s  <= operands.b_den[OW-1];
            busy  <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ad == '0 || bd == '0) begin
            result <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
            state  <= S_OUT;
          end else if (func == FUNC_DIV && bn == '0) begin
            result <= '{res_num: '0, res_den: '0, status: ST_DIV_ZERO};
            state  <= S_OUT;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1    <= prod;
          p1_s  <= an_s ^ ((func == FUNC_MUL) ? bn_s : bd_s);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= prod;
          p2_s  <= bn_s ^ ad_s ^ (func == FUNC_SUB);
          state <= S_MUL3;
        end
        S_MUL3: begin
          den   <= prod;
          den_s <= ad_s ^ ((func == FUNC_DIV) ? bn_s : bd_s);
          state <= S_SUM;
        end
        S_SUM: begin
          // combine cross products in sign-magnitude form for add and subtract;
          if (func == FUNC_ADD || func == FUNC_SUB) begin
            if (p1_s == p2_s) begin
              num <= p1 + p2;   num_s <= p1_s;
            end else if (p1 >= p2) begin
              num <= p1 - p2;   num_s <= p1_s;
            end else begin
              num <= p2 - p1;   num_s <= p2_s;
            end
          end else begin
            num   <= p1;
            num_s <= p1_s;
          end
          state <= S_GCD;
        end
        S_GCD: begin
          // seed the Euclid pair, a zero numerator reduces to 0/1
          if (num == '0) begin
            result <= '{res_num: '0, res_den: ResDenWidth'(1), status: ST_OK};
            state  <= S_OUT;
          end else begin
            gx    <= num;
            gy    <= den;
            state <= S_STEP;
          end
        end
        S_STEP: state <= S_GCDW;
        S_GCDW: begin
          if (div_done) begin
            if (div_r == '0) begin
              gx    <= gy;
              state <= S_DIVN;
            end else begin
              gx    <= gy;
              gy    <= div_r;
              state <= S_STEP;
            end
          end
        end
        S_DIVN:  state <= S_DIVNW;
        S_DIVNW: begin
          if (div_done) begin
            num   <= div_q;
            state <= S_DIVD;
          end
        end
        S_DIVD:  state <= S_DIVDW;
        S_DIVDW: begin
          if (div_done) begin
            result <= '{
              res_num: (num_s ^ den_s) ? -ResNumWidth'(num) : ResNumWidth'(num),
              res_den: ResDenWidth'(div_q),
              status:  ST_OK
            };
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          valid <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> state == S_IDLE) else $error("valid outside idle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_valid_fall: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy) else $error("busy held with valid");

endmodule
